### src/mrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MRP registrar table package
// Shared types and constants for the registrar table and its sweep engine.
// ----------------------------------------------------------------------------
package mrp_pkg;

    localparam int ENTRIES_DEF = 256;

    localparam logic [1:0] CMD_EVENT    = 2'd0;
    localparam logic [1:0] CMD_LEAVEALL = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    localparam logic [1:0] ST_MT = 2'd0;
    localparam logic [1:0] ST_IN = 2'd1;
    localparam logic [1:0] ST_LV = 2'd2;

    localparam logic [2:0] EV_NEW    = 3'd0;
    localparam logic [2:0] EV_JOININ = 3'd1;
    localparam logic [2:0] EV_JOINMT = 3'd3;
    localparam logic [2:0] EV_LV     = 3'd5;

    localparam logic [9:0] LEAVE_RESET = 10'd1000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ALLOC,
        S_DONE
    } t_state;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic [1:0]  protocol;
        logic [3:0]  kind;
        logic [63:0] key;
        logic [47:0] source;
        logic [1:0]  state;
        logic [31:0] timer;
        logic [31:0] events;
    } t_entry;

    // The transaction held while the sweep runs.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  protocol;
        logic [3:0]  kind;
        logic [63:0] key;
        logic [47:0] source;
        logic [2:0]  event_code;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        logic [1:0]  state_after;
        logic [8:0]  changed_count;
        logic [8:0]  leaving_count;
        logic [31:0] entry_events;
        logic        table_full;
    } t_res;

    function automatic logic [8:0] sat_inc(input logic [8:0] v);
        return (v == 9'h1FF) ? v : v + 9'd1;
    endfunction

    function automatic logic [31:0] ev_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

### src/mrp_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MRP registrar entry memory
// Simple dual-port synchronous memory with registered read data and valid bits.
// ----------------------------------------------------------------------------
module mrp_mem #(
    parameter int ENTRIES = mrp_pkg::ENTRIES_DEF,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [AW-1:0]        i_raddr,
    input  logic [AW-1:0]        i_waddr,
    input  logic                 i_we,
    input  mrp_pkg::t_entry      i_wdata,
    output mrp_pkg::t_entry      o_rdata,
    output logic                 o_rvalid
);

    mrp_pkg::t_entry r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

    // Valid bits live in flip-flops so that reset empties the table at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            o_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            o_rvalid <= r_valid[i_raddr];
        end
    end

endmodule

### src/mrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MRP registrar sweep controller
// Walks the entry memory at most once per transaction, reading, updating and
// writing back entries, then forms the result.
// ----------------------------------------------------------------------------
module mrp_ctrl #(
    parameter int ENTRIES = mrp_pkg::ENTRIES_DEF,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mrp_pkg::t_req     i_req,
    input  logic [9:0]        i_leave,
    input  logic              i_res_taken,
    output logic              o_busy,
    output logic              o_res_valid,
    output mrp_pkg::t_res     o_res,
    output logic [AW-1:0]     o_raddr,
    output logic [AW-1:0]     o_waddr,
    output logic              o_we,
    output mrp_pkg::t_entry   o_wdata,
    input  mrp_pkg::t_entry   i_rdata,
    input  logic              i_rvalid
);

    mrp_pkg::t_state r_st, n_st;
    mrp_pkg::t_req   r_req;
    logic [AW:0]     r_idx, n_idx;      // address being read
    logic [AW-1:0]   r_cur, n_cur;      // address whose data is on i_rdata
    logic            r_hit, n_hit;
    logic            r_free_ok, n_free_ok;
    logic [AW-1:0]   r_free, n_free;
    logic [8:0]      r_lv, n_lv;
    logic [8:0]      r_chg, n_chg;
    mrp_pkg::t_res   r_res, n_res;
    mrp_pkg::t_entry r_new;

    logic            match;
    logic            last;
    mrp_pkg::t_entry upd;
    logic            upd_we;
    logic            upd_chg;
    logic [8:0]      lv_dec, lv_inc;
    logic [31:0]     elapsed;

    assign last    = (r_cur == AW'(ENTRIES - 1));
    assign elapsed = r_req.now - i_rdata.timer;
    assign match   = i_rvalid && (i_rdata.protocol == r_req.protocol)
                     && (i_rdata.key == r_req.key) && (i_rdata.source == r_req.source);
    assign lv_dec  = (r_lv != 9'd0) ? r_lv - 9'd1 : r_lv;

    // Per-entry update for the command being run.
    always_comb begin
        upd     = i_rdata;
        upd_we  = 1'b0;
        upd_chg = 1'b0;
        lv_inc  = r_lv;
        unique case (r_req.cmd)
            mrp_pkg::CMD_LEAVEALL: begin
                if (i_rvalid && i_rdata.protocol == r_req.protocol
                    && i_rdata.kind == r_req.kind && i_rdata.state == mrp_pkg::ST_IN) begin
                    upd.timer  = r_req.now;
                    upd.events = mrp_pkg::ev_inc(i_rdata.events);
                    upd.state  = mrp_pkg::ST_LV;
                    upd_we     = 1'b1;
                    upd_chg    = 1'b1;
                    lv_inc     = r_lv + 9'd1;
                end
            end
            mrp_pkg::CMD_TICK: begin
                if (i_rvalid && i_rdata.state == mrp_pkg::ST_LV
                    && elapsed > {22'd0, i_leave}) begin
                    upd.timer = '0;
                    upd.state = mrp_pkg::ST_MT;
                    upd_we    = 1'b1;
                    upd_chg   = 1'b1;
                    lv_inc    = lv_dec;
                end
            end
            default: begin
            end
        endcase
    end

    // Event applied to a found or freshly allocated entry.
    function automatic mrp_pkg::t_entry apply_ev(input mrp_pkg::t_entry e,
                                                 input mrp_pkg::t_req q);
        mrp_pkg::t_entry r;
        r        = e;
        r.kind   = q.kind;
        r.events = mrp_pkg::ev_inc(e.events);
        if (q.event_code == mrp_pkg::EV_NEW || q.event_code == mrp_pkg::EV_JOININ
            || q.event_code == mrp_pkg::EV_JOINMT) begin
            r.state = mrp_pkg::ST_IN;
            r.timer = '0;
        end else if (q.event_code == mrp_pkg::EV_LV && e.state == mrp_pkg::ST_IN) begin
            r.state = mrp_pkg::ST_LV;
            r.timer = q.now;
        end
        return r;
    endfunction

    mrp_pkg::t_entry ev_upd;
    mrp_pkg::t_entry fresh;
    always_comb begin
        fresh          = '0;
        fresh.protocol = r_req.protocol;
        fresh.key      = r_req.key;
        fresh.source   = r_req.source;
        fresh.state    = mrp_pkg::ST_MT;
        ev_upd         = apply_ev(r_hit ? r_new : fresh, r_req);
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            mrp_pkg::S_IDLE:  if (i_start) n_st = mrp_pkg::S_READ;
            // A nonzero start index marks a transaction that skips the sweep.
            mrp_pkg::S_READ:  n_st = (r_idx != '0) ? mrp_pkg::S_DONE : mrp_pkg::S_EVAL;
            mrp_pkg::S_EVAL: begin
                if (r_req.cmd == mrp_pkg::CMD_EVENT) begin
                    if (match || last) n_st = mrp_pkg::S_ALLOC;
                end else if (last) begin
                    n_st = mrp_pkg::S_DONE;
                end
            end
            mrp_pkg::S_ALLOC: n_st = mrp_pkg::S_DONE;
            mrp_pkg::S_DONE:  if (i_res_taken) n_st = mrp_pkg::S_IDLE;
            default:          n_st = mrp_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_hit     = r_hit;
        n_free_ok = r_free_ok;
        n_free    = r_free;
        n_lv      = r_lv;
        n_chg     = r_chg;
        n_res     = r_res;
        o_raddr   = r_idx[AW-1:0];
        o_waddr   = r_cur;
        o_we      = 1'b0;
        o_wdata   = upd;
        unique case (r_st)
            mrp_pkg::S_IDLE: begin
                n_idx     = '0;
                n_cur     = '0;
                n_hit     = 1'b0;
                n_free_ok = 1'b0;
                n_chg     = '0;
                // Tick with nothing leaving and unused commands skip the sweep.
                if (i_start && (i_req.cmd == mrp_pkg::CMD_UNUSED
                                || (i_req.cmd == mrp_pkg::CMD_TICK && r_lv == 9'd0))) begin
                    n_idx = (AW+1)'(ENTRIES);
                end
            end
            mrp_pkg::S_READ: begin
                o_raddr = '0;
                n_idx   = (AW+1)'(1);
                n_cur   = '0;
            end
            mrp_pkg::S_EVAL: begin
                // Write back at the address just read; next read follows.
                if (r_req.cmd == mrp_pkg::CMD_EVENT) begin
                    if (!i_rvalid && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_cur;
                    end
                    if (match) begin
                        n_hit  = 1'b1;
                        n_free = r_cur;
                    end
                end else begin
                    o_we    = upd_we;
                    o_waddr = r_cur;
                    o_wdata = upd;
                    n_lv    = lv_inc;
                    if (upd_chg) n_chg = mrp_pkg::sat_inc(r_chg);
                end
                n_cur = r_idx[AW-1:0];
                n_idx = r_idx + (AW+1)'(1);
            end
            mrp_pkg::S_ALLOC: begin
                n_res = '0;
                if (r_hit || r_free_ok) begin
                    o_we    = 1'b1;
                    o_waddr = r_free;
                    o_wdata = ev_upd;
                    if (ev_upd.state != (r_hit ? r_new.state : mrp_pkg::ST_MT)) begin
                        n_chg = 9'd1;
                        if (ev_upd.state == mrp_pkg::ST_LV) n_lv = r_lv + 9'd1;
                        else if (r_hit && r_new.state == mrp_pkg::ST_LV) n_lv = lv_dec;
                    end
                    n_res.state_after  = ev_upd.state;
                    n_res.entry_events = ev_upd.events;
                end else begin
                    n_res.table_full = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Reads run one address ahead of the write-back, so during a sweep the
    // read and write ports never address the same entry in one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= mrp_pkg::S_IDLE;
            r_lv <= '0;
        end else begin
            r_st <= n_st;
            r_lv <= n_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == mrp_pkg::S_IDLE && i_start) r_req <= i_req;
        r_idx     <= n_idx;
        r_cur     <= n_cur;
        r_hit     <= n_hit;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_chg     <= n_chg;
        r_res     <= n_res;
        if (r_st == mrp_pkg::S_EVAL && match && !r_hit) r_new <= i_rdata;
    end

    always_comb begin
        o_busy      = (r_st != mrp_pkg::S_IDLE);
        o_res_valid = (r_st == mrp_pkg::S_DONE);
        o_res       = r_res;
        if (r_req.cmd != mrp_pkg::CMD_EVENT) begin
            o_res               = '0;
            o_res.changed_count = r_chg;
        end
        o_res.leaving_count = r_lv;
        if (r_req.cmd == mrp_pkg::CMD_EVENT) o_res.changed_count = r_res.table_full ? 9'd0
                                                                   : r_chg;
    end

endmodule

### src/mrp_registrar_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MRP registrar table
// Bounded table of registrar entries with event, leave-all and tick commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    cmd, protocol, kind, key, mac, ...
// result    out        o_valid / i_ready    state_after, counts, events, full
// config    in         i_cfg_we             i_cfg_data (leave time, ms)
//
// A leave-all or tick reads every entry once, one per cycle, and the input is
// ready again once its result has moved into the output register. An event
// stops at its matching entry, or reads every entry when none matches. A tick
// with no entry in LV and an unused command skip the sweep. Reset empties the
// table at once through per-entry valid bits. The result sits in an output
// register, so only a second finished result waits on it.
// ----------------------------------------------------------------------------
module mrp_registrar_table_top #(
    parameter int ENTRIES = mrp_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_protocol,
    input  logic [3:0]  i_attr_kind,
    input  logic [63:0] i_attr_key,
    input  logic [47:0] i_source_mac,
    input  logic [2:0]  i_event_code,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_state_after,
    output logic [8:0]  o_changed_count,
    output logic [8:0]  o_leaving_count,
    output logic [31:0] o_entry_events,
    output logic        o_table_full
);

    localparam int AW = $clog2(ENTRIES);

    logic [9:0]      r_leave;
    mrp_pkg::t_req   req;
    mrp_pkg::t_res   res;
    logic            res_valid;
    logic            res_taken;
    logic            r_out_valid;
    mrp_pkg::t_res   r_out;
    logic            busy;
    logic [AW-1:0]   raddr, waddr;
    logic            we;
    mrp_pkg::t_entry wdata, rdata;
    logic            rvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_leave <= mrp_pkg::LEAVE_RESET;
        else if (i_cfg_we) r_leave <= i_cfg_data;
    end

    assign req     = '{i_cmd, i_protocol, i_attr_kind, i_attr_key, i_source_mac,
                       i_event_code, i_now_ms};
    assign o_ready = !busy;

    mrp_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raddr(raddr), .i_waddr(waddr), .i_we(we),
        .i_wdata(wdata), .o_rdata(rdata), .o_rvalid(rvalid)
    );

    mrp_ctrl #(.ENTRIES(ENTRIES), .AW(AW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_valid && !busy), .i_req(req),
        .i_leave(r_leave), .i_res_taken(res_taken), .o_busy(busy),
        .o_res_valid(res_valid), .o_res(res), .o_raddr(raddr), .o_waddr(waddr),
        .o_we(we), .o_wdata(wdata), .i_rdata(rdata), .i_rvalid(rvalid)
    );

    // The output register takes a new result when it is empty or being drained.
    assign res_taken = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_taken) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_taken) r_out <= res;
    end

    assign o_valid         = r_out_valid;
    assign o_state_after   = r_out.state_after;
    assign o_changed_count = r_out.changed_count;
    assign o_leaving_count = r_out.leaving_count;
    assign o_entry_events  = r_out.entry_events;
    assign o_table_full    = r_out.table_full;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_out)))
        else $error("waiting result changed");
    a_full_no_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_changed_count == 9'd0 && o_entry_events == 32'd0))
        else $error("full table reported a change");
    a_out_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("accept did not start work");

endmodule
